// File: sv/mpq_pkg.sv
package mpq_pkg;

	localparam int HEAP_DEPTH_DEF = 64;

	typedef logic signed [31:0] key_t;

	// operation kinds
	localparam logic [1:0] OP_INSERT   = 2'd0;
	localparam logic [1:0] OP_EXTRACT  = 2'd1;
	localparam logic [1:0] OP_PEEK     = 2'd2;
	localparam logic [1:0] OP_INCREASE = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

endpackage

// File: sv/mpq_store.sv
// Heap key store: one write port, two read ports, registered read data.
module mpq_store #(
	parameter int HEAP_DEPTH = mpq_pkg::HEAP_DEPTH_DEF,
	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  mpq_pkg::key_t wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output mpq_pkg::key_t rdata_a,
	output mpq_pkg::key_t rdata_b
);

	mpq_pkg::key_t mem [HEAP_DEPTH];
	mpq_pkg::key_t rdata_a_q;
	mpq_pkg::key_t rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// File: sv/max_priority_queue_core.sv
// Binary max-heap priority queue of signed 32-bit keys. Each input beat carries one
// operation (insert, extract maximum, peek maximum, increase the key at a 1-based heap
// position) and yields exactly one output beat with the key (extract/peek, else zero),
// a status (ok, empty, full, ignored) and the number of keys held afterwards. Keys live
// in a synchronous two-read, one-write store with registered read data; a small
// sequencer walks the heap one level at a time (read, then compare and write back),
// carrying the moving key in a register so each level costs a single write. The key
// moves at most log2(HEAP_DEPTH) levels for insert and increase and one less for
// extract. One operation is in flight at a time; the result sits in an output
// register, so the next operation is taken while the previous result waits to be
// collected. The store needs no clearing after reset: only slots 1..entry_count are
// ever read.
module max_priority_queue_core #(
	parameter int HEAP_DEPTH = mpq_pkg::HEAP_DEPTH_DEF,
	localparam int CW = $clog2(HEAP_DEPTH + 1),
	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    kind,
	input  mpq_pkg::key_t key_value,
	input  logic [CW-1:0] heap_position,
	output logic          out_valid,
	input  logic          out_ready,
	output mpq_pkg::key_t result_value,
	output logic [1:0]    status,
	output logic [CW-1:0] entry_count
);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXRD  = 4'd1;  // root and last key arriving
	localparam logic [3:0] S_PKRD  = 4'd2;  // root arriving
	localparam logic [3:0] S_INRD  = 4'd3;  // key at position arriving
	localparam logic [3:0] S_UPRD  = 4'd4;  // issue parent read
	localparam logic [3:0] S_UPCMP = 4'd5;
	localparam logic [3:0] S_DNRD  = 4'd6;  // issue child reads
	localparam logic [3:0] S_DNCMP = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;  // hand result to output register

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] pos_q, pos_d;       // slot of the hole being moved
	mpq_pkg::key_t val_q, val_d;       // key that travels with the hole
	mpq_pkg::key_t key_q;              // key of the accepted beat
	mpq_pkg::key_t res_q, res_d;
	logic [1:0]    st_q, st_d;

	logic          out_valid_q;
	mpq_pkg::key_t out_val_q;
	logic [1:0]    out_st_q;
	logic [CW-1:0] out_cnt_q;

	// store ports
	logic          we;
	logic [AW-1:0] waddr;
	mpq_pkg::key_t wdata;
	logic [AW-1:0] raddr_a, raddr_b;
	mpq_pkg::key_t rdata_a, rdata_b;

	logic          in_fire;
	logic          full;
	logic [CW:0]   lft_slot, rgt_slot, top_slot;
	logic          lft_ok, rgt_ok;
	mpq_pkg::key_t top_val;
	logic [CW-1:0] parent;

	mpq_store #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign full     = (count_q == CW'(HEAP_DEPTH));
	assign parent   = pos_q >> 1;

	// children of the current hole; a child past the count does not exist
	assign lft_slot = {pos_q, 1'b0};
	assign rgt_slot = {pos_q, 1'b1};
	assign lft_ok   = (lft_slot <= {1'b0, count_q});
	assign rgt_ok   = (rgt_slot <= {1'b0, count_q});

	// larger child wins; right only if strictly above left (and above the key)
	always_comb begin
		top_slot = {1'b0, pos_q};
		top_val  = val_q;
		if (lft_ok && (rdata_a > top_val)) begin
			top_slot = lft_slot;
			top_val  = rdata_a;
		end
		if (rgt_ok && (rdata_b > top_val)) begin
			top_slot = rgt_slot;
			top_val  = rdata_b;
		end
	end

	// read addresses (slot s sits at index s-1)
	always_comb begin
		raddr_a = '0;
		raddr_b = '0;
		case (state_q)
			S_IDLE: begin
				if (kind == mpq_pkg::OP_INCREASE) begin
					raddr_a = AW'(heap_position - 1'b1);
				end
				raddr_b = AW'(count_q - 1'b1);
			end
			S_UPRD: begin
				raddr_a = AW'(parent - 1'b1);
			end
			S_DNRD: begin
				if (lft_ok) begin
					raddr_a = AW'(lft_slot - 1'b1);
				end
				if (rgt_ok) begin
					raddr_b = AW'(lft_slot);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d   = pos_q;
		val_d   = val_q;
		res_d   = res_q;
		st_d    = st_q;
		we      = 1'b0;
		waddr   = AW'(pos_q - 1'b1);
		wdata   = val_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					res_d = '0;
					st_d  = mpq_pkg::ST_OK;
					case (kind)
						mpq_pkg::OP_INSERT: begin
							if (full) begin
								st_d    = mpq_pkg::ST_FULL;
								state_d = S_FIN;
							end else begin
								count_d = count_q + 1'b1;
								pos_d   = count_q + 1'b1;
								val_d   = key_value;
								state_d = S_UPRD;
							end
						end
						mpq_pkg::OP_EXTRACT: begin
							if (count_q == '0) begin
								st_d    = mpq_pkg::ST_EMPTY;
								state_d = S_FIN;
							end else begin
								state_d = S_EXRD;
							end
						end
						mpq_pkg::OP_PEEK: begin
							if (count_q == '0) begin
								st_d    = mpq_pkg::ST_EMPTY;
								state_d = S_FIN;
							end else begin
								state_d = S_PKRD;
							end
						end
						default: begin
							if ((heap_position == '0) || (heap_position > count_q)) begin
								st_d    = mpq_pkg::ST_IGNORED;
								state_d = S_FIN;
							end else begin
								pos_d   = heap_position;
								state_d = S_INRD;
							end
						end
					endcase
				end
			end
			S_EXRD: begin
				// last key drops into the root hole, then sifts down
				res_d   = rdata_a;
				val_d   = rdata_b;
				count_d = count_q - 1'b1;
				pos_d   = CW'(1);
				state_d = S_DNRD;
			end
			S_PKRD: begin
				res_d   = rdata_a;
				state_d = S_FIN;
			end
			S_INRD: begin
				if (key_q < rdata_a) begin
					st_d    = mpq_pkg::ST_IGNORED;
					state_d = S_FIN;
				end else begin
					val_d   = key_q;
					state_d = S_UPRD;
				end
			end
			S_UPRD: begin
				if (pos_q == CW'(1)) begin
					we      = 1'b1;
					state_d = S_FIN;
				end else begin
					state_d = S_UPCMP;
				end
			end
			S_UPCMP: begin
				we = 1'b1;
				if (rdata_a < val_q) begin
					wdata   = rdata_a;
					pos_d   = parent;
					state_d = S_UPRD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DNRD: begin
				state_d = S_DNCMP;
			end
			S_DNCMP: begin
				we = 1'b1;
				if (top_slot == {1'b0, pos_q}) begin
					state_d = S_FIN;
				end else begin
					wdata   = top_val;
					pos_d   = top_slot[CW-1:0];
					state_d = S_DNRD;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if ((state_q == S_FIN) && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready && !(state_q == S_FIN)) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and output payload
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		val_q <= val_d;
		res_q <= res_d;
		st_q  <= st_d;
		if (in_fire) begin
			key_q <= key_value;
		end
		if ((state_q == S_FIN) && (!out_valid_q || out_ready)) begin
			out_val_q <= res_q;
			out_st_q  <= st_q;
			out_cnt_q <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_val_q;
	assign status       = out_st_q;
	assign entry_count  = out_cnt_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HEAP_DEPTH))
		else $error("held count above depth");

	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != mpq_pkg::ST_OK)) |-> (result_value == '0))
		else $error("nonzero result with failing status");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (kind == mpq_pkg::OP_INSERT) && !full)
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the count");

	a_extract_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (kind == mpq_pkg::OP_EXTRACT) && (count_q != '0))
		|=> ##1 (count_q == $past(count_q, 2) - 1'b1))
		else $error("extract did not shrink the count");

	a_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> ((state_q == S_UPRD) || (state_q == S_UPCMP) || (state_q == S_DNCMP)))
		else $error("store write outside a sift step");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int HEAP_SLOTS = mpq_pkg::HEAP_DEPTH_DEF;
	localparam int CW = $clog2(HEAP_SLOTS + 1);
	// cycles with no beat on either side before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	localparam longint KEY_MAX = 64'sd2147483647;
	localparam longint KEY_MIN = -64'sd2147483648;

	typedef struct {
		mpq_pkg::key_t value;
		logic [1:0]    st;
		int            cnt;
	} heap_outcome_t;

	// Software copy of the heap: applies each accepted op, queues the result
	// it must produce, and compares returned beats in order.
	class heap_tracker;
		mpq_pkg::key_t slots [1:HEAP_SLOTS];
		int held;
		heap_outcome_t pending[$];
		int mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function void swap_slots(int a, int b);
			mpq_pkg::key_t t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		function void bubble_up(int p);
			while (p > 1 && slots[p / 2] < slots[p]) begin
				swap_slots(p / 2, p);
				p = p / 2;
			end
		endfunction

		function void bubble_down(int p);
			int top;
			bit done;
			done = 0;
			while (!done) begin
				top = p;
				if (2 * p <= held && slots[2 * p] > slots[top])
					top = 2 * p;
				if (2 * p + 1 <= held && slots[2 * p + 1] > slots[top])
					top = 2 * p + 1;
				if (top == p) begin
					done = 1;
				end else begin
					swap_slots(p, top);
					p = top;
				end
			end
		endfunction

		function void note_op(logic [1:0] op, mpq_pkg::key_t key, int pos);
			heap_outcome_t o;
			o.value = '0;
			o.st = mpq_pkg::ST_OK;
			case (op)
				mpq_pkg::OP_INSERT: begin
					if (held >= HEAP_SLOTS) begin
						o.st = mpq_pkg::ST_FULL;
					end else begin
						held++;
						slots[held] = key;
						bubble_up(held);
					end
				end
				mpq_pkg::OP_EXTRACT: begin
					if (held == 0) begin
						o.st = mpq_pkg::ST_EMPTY;
					end else begin
						o.value = slots[1];
						slots[1] = slots[held];
						held--;
						bubble_down(1);
					end
				end
				mpq_pkg::OP_PEEK: begin
					if (held == 0)
						o.st = mpq_pkg::ST_EMPTY;
					else
						o.value = slots[1];
				end
				default: begin
					if (pos == 0 || pos > held || key < slots[pos]) begin
						o.st = mpq_pkg::ST_IGNORED;
					end else begin
						slots[pos] = key;
						bubble_up(pos);
					end
				end
			endcase
			o.cnt = held;
			pending.push_back(o);
		endfunction

		function void check_result(mpq_pkg::key_t v, logic [1:0] st, logic [CW-1:0] cnt);
			heap_outcome_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat: value %0d status %0d count %0d",
					$time, v, st, cnt);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.value) begin
				$display("%0t: result_value expected %0d, got %0d", $time, e.value, v);
				mismatches++;
			end
			if (st !== e.st) begin
				$display("%0t: status expected %0d, got %0d", $time, e.st, st);
				mismatches++;
			end
			if (cnt !== e.cnt[CW-1:0]) begin
				$display("%0t: entry_count expected %0d, got %0d", $time, e.cnt, cnt);
				mismatches++;
			end
		endfunction
	endclass

	// every DUT input starts at a known value
	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [1:0]    kind = mpq_pkg::OP_PEEK;
	mpq_pkg::key_t key_value = '0;
	logic [CW-1:0] heap_position = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	mpq_pkg::key_t result_value;
	logic [1:0]    status;
	logic [CW-1:0] entry_count;

	// idle odds in percent, changed per phase
	int send_idle = 0;
	int recv_idle = 0;
	int stall_cycles = 0;
	heap_tracker tracker = new();

	max_priority_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.key_value    (key_value),
		.heap_position(heap_position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status),
		.entry_count  (entry_count)
	);

	always #5 clk = ~clk;

	// receiver: ready drops at random, one update per edge
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// result monitor: values sampled at the edge are the pre-edge ones
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(result_value, status, entry_count);
	end

	// hang detector: any beat on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL max_priority_queue_core");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Drive one op and hold it until the beat is taken. Called at a rising
	// edge; valid is only lowered when a gap is inserted, so it never falls
	// and rises in the same step.
	task automatic send_op(input logic [1:0] op, input mpq_pkg::key_t key, input int pos);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		key_value <= key;
		heap_position <= pos[CW-1:0];
		do @(posedge clk); while (!in_ready);
		tracker.note_op(op, key, int'(pos[CW-1:0]));
	endtask

	function automatic mpq_pkg::key_t rand_key();
		case ($urandom_range(9))
			0: return mpq_pkg::key_t'(KEY_MAX);
			1: return mpq_pkg::key_t'(KEY_MIN);
			2: return mpq_pkg::key_t'(int'($urandom_range(16)) - 8);  // many duplicates
			default: return mpq_pkg::key_t'($urandom);
		endcase
	endfunction

	// Known sequence: empty-heap ops, extreme keys, every increase outcome,
	// draining past empty.
	task automatic run_directed();
		send_op(mpq_pkg::OP_PEEK, 0, 0);
		send_op(mpq_pkg::OP_EXTRACT, 0, 127);
		send_op(mpq_pkg::OP_INCREASE, 5, 1);                          // nothing held yet
		send_op(mpq_pkg::OP_INSERT, 0, 0);
		send_op(mpq_pkg::OP_INSERT, mpq_pkg::key_t'(KEY_MAX), 0);
		send_op(mpq_pkg::OP_INSERT, mpq_pkg::key_t'(KEY_MIN), 0);
		send_op(mpq_pkg::OP_INSERT, -1, 127);
		// heap now: max, 0, min, -1
		send_op(mpq_pkg::OP_PEEK, 0, 0);
		send_op(mpq_pkg::OP_INCREASE, mpq_pkg::key_t'(KEY_MAX), 0);   // slot zero
		send_op(mpq_pkg::OP_INCREASE, mpq_pkg::key_t'(KEY_MAX), 127); // far past count
		send_op(mpq_pkg::OP_INCREASE, -1, 2);                         // smaller than slot 2
		send_op(mpq_pkg::OP_INCREASE, mpq_pkg::key_t'(KEY_MIN), 3);   // equal key
		send_op(mpq_pkg::OP_INCREASE, mpq_pkg::key_t'(KEY_MAX), 4);   // larger, sifts up
		send_op(mpq_pkg::OP_INCREASE, 1, 5);                          // one past count
		repeat (5) send_op(mpq_pkg::OP_EXTRACT, 0, 0);                // last one hits empty
		send_op(mpq_pkg::OP_INSERT, mpq_pkg::key_t'(KEY_MIN), 0);
		send_op(mpq_pkg::OP_INSERT, mpq_pkg::key_t'(32'h5555_5555), 85);
		send_op(mpq_pkg::OP_INSERT, mpq_pkg::key_t'(32'haaaa_aaaa), 42);
		send_op(mpq_pkg::OP_PEEK, 0, 0);
		send_op(mpq_pkg::OP_EXTRACT, 0, 0);
		send_op(mpq_pkg::OP_EXTRACT, 0, 0);
	endtask

	// Random ops in runs of 96 with a bias: grow (reaches full), drain
	// (reaches empty) or mixed. Increases mostly target live slots with
	// larger, equal or smaller keys; the rest use slot zero, a random position or a random key.
	task automatic run_random(input int n);
		int i, mode, r, sel, pos, ins_pct, ext_pct, peek_pct;
		logic [1:0] op;
		mpq_pkg::key_t key;
		longint x;
		mode = 0;
		for (i = 0; i < n; i++) begin
			if (i % 96 == 0)
				mode = $urandom_range(2);
			case (mode)
				0: begin ins_pct = 70; ext_pct = 10; peek_pct = 5; end
				1: begin ins_pct = 15; ext_pct = 65; peek_pct = 5; end
				default: begin ins_pct = 30; ext_pct = 30; peek_pct = 15; end
			endcase
			r = $urandom_range(99);
			if (r < ins_pct)
				op = mpq_pkg::OP_INSERT;
			else if (r < ins_pct + ext_pct)
				op = mpq_pkg::OP_EXTRACT;
			else if (r < ins_pct + ext_pct + peek_pct)
				op = mpq_pkg::OP_PEEK;
			else
				op = mpq_pkg::OP_INCREASE;
			key = rand_key();
			pos = $urandom_range(127);
			if (op == mpq_pkg::OP_INCREASE) begin
				sel = $urandom_range(9);
				if (sel == 1) begin
					pos = 0;
				end else if (tracker.held > 0 && sel != 0) begin
					pos = $urandom_range(tracker.held, 1);
					x = longint'(tracker.slots[pos]);
					if (sel == 2)
						x = x - longint'($urandom_range(1000, 1));
					else if (sel >= 4 && sel <= 8)
						x = x + longint'($urandom_range(1000, 1));
					if (x > KEY_MAX)
						x = KEY_MAX;
					if (x < KEY_MIN)
						x = KEY_MIN;
					// sel 9 keeps the fully random key
					if (sel != 9)
						key = mpq_pkg::key_t'(x);
				end
			end
			send_op(op, key, pos);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 1: sender idles 37%, receiver 55%
		send_idle = 37;
		recv_idle = 55;
		run_directed();
		run_random(630);

		// phase 2: swapped
		send_idle = 55;
		recv_idle = 37;
		run_random(630);

		// phase 3: back to back
		send_idle = 0;
		recv_idle = 0;
		run_random(640);

		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		// leave room for stray beats
		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("PASS max_priority_queue_core");
		else
			$display("FAIL max_priority_queue_core");
		$finish;
	end

endmodule
